FILE: design/lfu_page_replacement_macros.svh
// Assertion macros for the LFU page replacement block.
`ifndef LFU_PAGE_REPLACEMENT_MACROS_SVH
`define LFU_PAGE_REPLACEMENT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LFU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define LFU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/lfu_pkg.sv
// Shared types and constants of the LFU page replacement block.
package lfu_pkg;

   localparam int unsigned PAGE_W  = 32;
   localparam int unsigned USES_W  = 32;
   localparam int unsigned STAMP_W = 32;
   localparam int unsigned CFG_W   = 10;
   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(512);

   typedef struct packed {
      logic [PAGE_W-1:0]  page;
      logic [USES_W-1:0]  uses;
      logic [STAMP_W-1:0] stamp;
   } lfu_entry_type;

   typedef struct packed {
      logic match;   // entry holds the requested page
      logic better;  // entry goes before the current victim candidate
   } lfu_cmp_result_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE
   } lfu_state_type;

endpackage

FILE: design/lfu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lfu_ram #(
   parameter int unsigned WIDTH = 96,
   parameter int unsigned DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/lfu_cmp.sv
// Shared compare unit: page match and LFU/LRU victim ordering for one entry.
module lfu_cmp
   import lfu_pkg::*;
(
   input  lfu_entry_type       entry,
   input  logic [PAGE_W-1:0]   req_page,
   input  logic                best_valid,
   input  logic [USES_W-1:0]   best_uses,
   input  logic [STAMP_W-1:0]  best_stamp,
   output lfu_cmp_result_type  result
);

   always_comb begin
      result.match  = (entry.page == req_page);
      // strict order keeps the lowest slot on a full tie
      result.better = !best_valid
                      || (entry.uses < best_uses)
                      || ((entry.uses == best_uses) && (entry.stamp < best_stamp));
   end

endmodule

FILE: design/lfu_page_replacement.sv
// Top level of the LFU page replacement block: sequencer, state and result port.
//
// Fully associative page store with least-frequently-used replacement; ties on
// the use count go to the oldest stamp, then to the lowest slot. A request is
// taken when start is high and busy is low. The block then reads every filled
// slot from the entry RAM, one slot per cycle, through a single compare unit,
// then passes through a drain state, in which the last RAM read lands, and a
// decide state; an empty store skips the scan and the drain. busy stays high
// until the cycle in which the result is shown, so the next request can be
// taken at the edge that ends the strobe. The result is shown on the rsp_
// ports for exactly one cycle with rsp_valid high, and the receiver cannot
// stall it. rsp_evicted_page is zero unless rsp_evicted_valid is set.
// frames_in_use is written through csr_wr_en and csr_wr_data; the user must
// write it only while busy is low, as the block itself has no guard for it.
// 0 acts as 1 and values above MAX_FRAMES act as MAX_FRAMES. Lowering it
// below the current fill drops no page: later misses replace a victim and
// the fill stays where it is. Use counts saturate at all ones. Slots below
// the fill count are the valid ones, so reset needs no clearing pass over
// the RAM.
module lfu_page_replacement
   import lfu_pkg::*;
#(
   parameter int unsigned MAX_FRAMES = 512
) (
   input  logic                clock,
   input  logic                reset,
   // request
   input  logic                start,
   output logic                busy,
   input  logic [PAGE_W-1:0]   req_page_number,
   input  logic [STAMP_W-1:0]  req_access_stamp,
   // response
   output logic                rsp_valid,
   output logic                rsp_hit,
   output logic                rsp_evicted_valid,
   output logic [PAGE_W-1:0]   rsp_evicted_page,
   // configuration
   input  logic                csr_wr_en,
   input  logic [CFG_W-1:0]    csr_wr_data
);

   localparam int unsigned IDX_W = $clog2(MAX_FRAMES);
   localparam int unsigned CNT_W = $clog2(MAX_FRAMES + 1);
   localparam int unsigned CAP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(MAX_FRAMES);
   localparam logic [CAP_W-1:0] CAP_ONE = CAP_W'(1);

   // sequencer
   lfu_state_type state_ff, state_in;

   // configuration and fill count
   logic [CFG_W-1:0] cfg_frames_ff, cfg_frames_in;
   logic [CNT_W-1:0] filled_ff, filled_in;

   // scan address and read pipeline
   logic [IDX_W-1:0] scan_idx_ff, scan_idx_in;
   logic             rd_pending_ff, rd_pending_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;

   // latched request
   logic [PAGE_W-1:0]  req_page_ff, req_page_in;
   logic [STAMP_W-1:0] req_stamp_ff, req_stamp_in;

   // scan results
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   match_idx_ff, match_idx_in;
   logic [USES_W-1:0]  match_uses_ff, match_uses_in;
   logic               best_valid_ff, best_valid_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic [USES_W-1:0]  best_uses_ff, best_uses_in;
   logic [STAMP_W-1:0] best_stamp_ff, best_stamp_in;
   logic [PAGE_W-1:0]  best_page_ff, best_page_in;

   // response registers
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic              rsp_evict_ff, rsp_evict_in;
   logic [PAGE_W-1:0] rsp_page_ff, rsp_page_in;

   // RAM ports
   logic             ram_rd_en;
   logic [IDX_W-1:0] ram_rd_addr;
   lfu_entry_type    ram_rd_data;
   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   lfu_entry_type    ram_wr_data;

   lfu_cmp_result_type cmp;

   logic             accept;
   logic             last_issue;
   logic [CAP_W-1:0] capacity;
   logic             has_free;
   logic             do_fill;

   assign accept = start && (state_ff == ST_IDLE);

   // last slot address goes out this cycle
   assign last_issue = (CNT_W'(scan_idx_ff) == (filled_ff - CNT_W'(1)));

   // frames_in_use clamped to 1 .. MAX_FRAMES
   always_comb begin
      capacity = CAP_W'(cfg_frames_ff);
      if (capacity == '0) begin
         capacity = CAP_ONE;
      end else if (capacity > CAP_MAX) begin
         capacity = CAP_MAX;
      end
   end

   assign has_free = (CAP_W'(filled_ff) < capacity);
   assign do_fill  = has_free || !best_valid_ff;

   lfu_ram #(
      .WIDTH ($bits(lfu_entry_type)),
      .DEPTH (MAX_FRAMES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   lfu_cmp u_cmp (
      .entry      (ram_rd_data),
      .req_page   (req_page_ff),
      .best_valid (best_valid_ff),
      .best_uses  (best_uses_ff),
      .best_stamp (best_stamp_ff),
      .result     (cmp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (filled_ff == '0) ? ST_DECIDE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:  state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      busy          = (state_ff != ST_IDLE);
      ram_rd_en     = 1'b0;
      ram_rd_addr   = scan_idx_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = match_idx_ff;
      ram_wr_data   = '{page: req_page_ff, uses: USES_W'(1), stamp: req_stamp_ff};
      scan_idx_in   = scan_idx_ff;
      filled_in     = filled_ff;
      rsp_valid_in  = 1'b0;
      rsp_hit_in    = rsp_hit_ff;
      rsp_evict_in  = rsp_evict_ff;
      rsp_page_in   = rsp_page_ff;
      req_page_in   = req_page_ff;
      req_stamp_in  = req_stamp_ff;
      cfg_frames_in = csr_wr_en ? csr_wr_data : cfg_frames_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_page_in  = req_page_number;
               req_stamp_in = req_access_stamp;
               scan_idx_in  = '0;
            end
         end
         ST_SCAN: begin
            ram_rd_en   = 1'b1;
            scan_idx_in = scan_idx_ff + IDX_W'(1);
         end
         ST_DRAIN: begin
         end
         ST_DECIDE: begin
            ram_wr_en    = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_hit_in   = found_ff;
            rsp_evict_in = 1'b0;
            rsp_page_in  = '0;
            if (found_ff) begin
               // hit: bump count (saturating), take the new stamp
               ram_wr_addr = match_idx_ff;
               ram_wr_data.uses = (match_uses_ff == '1) ? match_uses_ff
                                                        : match_uses_ff + USES_W'(1);
            end else if (do_fill) begin
               ram_wr_addr = filled_ff[IDX_W-1:0];
               filled_in   = filled_ff + CNT_W'(1);
            end else begin
               ram_wr_addr  = best_idx_ff;
               rsp_evict_in = 1'b1;
               rsp_page_in  = best_page_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // scan bookkeeping: data read in one cycle is compared in the next
   always_comb begin
      rd_pending_in = ram_rd_en;
      rd_idx_in     = scan_idx_ff;
      found_in      = found_ff;
      match_idx_in  = match_idx_ff;
      match_uses_in = match_uses_ff;
      best_valid_in = best_valid_ff;
      best_idx_in   = best_idx_ff;
      best_uses_in  = best_uses_ff;
      best_stamp_in = best_stamp_ff;
      best_page_in  = best_page_ff;
      if (accept) begin
         found_in      = 1'b0;
         best_valid_in = 1'b0;
      end else if (rd_pending_ff) begin
         if (!found_ff && cmp.match) begin
            found_in      = 1'b1;
            match_idx_in  = rd_idx_ff;
            match_uses_in = ram_rd_data.uses;
         end
         if (cmp.better) begin
            best_valid_in = 1'b1;
            best_idx_in   = rd_idx_ff;
            best_uses_in  = ram_rd_data.uses;
            best_stamp_in = ram_rd_data.stamp;
            best_page_in  = ram_rd_data.page;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cfg_frames_ff <= CFG_RESET;
         filled_ff     <= '0;
         rd_pending_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         found_ff      <= 1'b0;
         best_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cfg_frames_ff <= cfg_frames_in;
         filled_ff     <= filled_in;
         rd_pending_ff <= rd_pending_in;
         rsp_valid_ff  <= rsp_valid_in;
         found_ff      <= found_in;
         best_valid_ff <= best_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_idx_ff   <= scan_idx_in;
      rd_idx_ff     <= rd_idx_in;
      req_page_ff   <= req_page_in;
      req_stamp_ff  <= req_stamp_in;
      match_idx_ff  <= match_idx_in;
      match_uses_ff <= match_uses_in;
      best_idx_ff   <= best_idx_in;
      best_uses_ff  <= best_uses_in;
      best_stamp_ff <= best_stamp_in;
      best_page_ff  <= best_page_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_evict_ff  <= rsp_evict_in;
      rsp_page_ff   <= rsp_page_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_evicted_valid = rsp_evict_ff;
   assign rsp_evicted_page  = rsp_page_ff;

endmodule

FILE: design/lfu_checker.sv
// Port-level checker for the LFU page replacement block, bound to the top level.
`include "lfu_page_replacement_macros.svh"

module lfu_checker
   import lfu_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input logic              rsp_hit,
   input logic              rsp_evicted_valid,
   input logic [PAGE_W-1:0] rsp_evicted_page
);

   // an accepted request makes the block busy in the next cycle
   `LFU_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "request not held busy")

   // a result strobe only follows a busy cycle
   `LFU_ASSERT_NOW(a_rsp_after_busy, clock, reset, rsp_valid, $past(busy), "strobe without request")

   // a single strobe per request
   `LFU_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "repeated result strobe")

   // a hit never evicts
   `LFU_ASSERT_NOW(a_hit_no_evict, clock, reset, rsp_valid && rsp_hit, !rsp_evicted_valid,
      "eviction on hit")

   // no eviction means a zero evicted page
   `LFU_ASSERT_NOW(a_evict_page_zero, clock, reset, rsp_valid && !rsp_evicted_valid,
      rsp_evicted_page == '0, "evicted page not zero")

endmodule

bind lfu_page_replacement lfu_checker u_lfu_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_hit           (rsp_hit),
   .rsp_evicted_valid (rsp_evicted_valid),
   .rsp_evicted_page  (rsp_evicted_page)
);

FILE: verif/lfu_store_mirror_pkg.sv
// Mirror of the LFU page store: predicts each access outcome and checks the responses.
package lfu_store_mirror_pkg;
   import lfu_pkg::*;

   typedef struct {
      logic               hit;
      logic               evicted_valid;
      logic [PAGE_W-1:0]  evicted_page;
   } page_outcome_type;

   class lfu_store_mirror;
      int unsigned        depth;
      logic [CFG_W-1:0]   frames_reg;
      int unsigned        filled;       // slots below this are resident
      logic [PAGE_W-1:0]  slot_page[];
      logic [USES_W-1:0]  slot_uses[];
      logic [STAMP_W-1:0] slot_stamp[];
      page_outcome_type   due_outcomes[$];
      int unsigned        mismatches;

      function new(int unsigned table_depth);
         depth = table_depth;
         frames_reg = CFG_RESET;
         filled = 0;
         mismatches = 0;
         slot_page = new[table_depth];
         slot_uses = new[table_depth];
         slot_stamp = new[table_depth];
      endfunction

      // Apply one accepted request to the mirrored store and queue its outcome.
      function void note_access(logic [PAGE_W-1:0] page, logic [STAMP_W-1:0] stamp);
         int               hit_slot;
         int               victim;
         int unsigned      cap;
         int unsigned      slot;
         page_outcome_type outcome;
         hit_slot = -1;
         victim = -1;
         cap = frames_reg;
         if (cap == 0)
            cap = 1;
         if (cap > depth)
            cap = depth;
         outcome.hit = 1'b0;
         outcome.evicted_valid = 1'b0;
         outcome.evicted_page = '0;
         for (int i = 0; i < filled; i++) begin
            if (hit_slot < 0 && slot_page[i] == page)
               hit_slot = i;
            // fewer uses first, then older stamp; strict compare keeps the lowest slot
            if (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                (slot_uses[i] == slot_uses[victim] && slot_stamp[i] < slot_stamp[victim]))
               victim = i;
         end
         if (hit_slot >= 0) begin
            if (slot_uses[hit_slot] != '1)
               slot_uses[hit_slot] += 1;
            slot_stamp[hit_slot] = stamp;
            outcome.hit = 1'b1;
         end else begin
            if (filled < cap || victim < 0) begin
               slot = filled;
               filled++;
            end else begin
               slot = victim;
               outcome.evicted_valid = 1'b1;
               outcome.evicted_page = slot_page[slot];
            end
            slot_page[slot] = page;
            slot_uses[slot] = 1;
            slot_stamp[slot] = stamp;
         end
         due_outcomes = {due_outcomes, outcome};
      endfunction

      function void check_outcome(logic hit, logic evicted_valid, logic [PAGE_W-1:0] evicted_page);
         page_outcome_type want;
         if (due_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%t: response with no request outstanding: hit=%b ev=%b page=%h",
                        $realtime, hit, evicted_valid, evicted_page);
            return;
         end
         want = due_outcomes.pop_front();
         if (hit !== want.hit || evicted_valid !== want.evicted_valid ||
             evicted_page !== want.evicted_page) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%t: mismatch: expected hit=%b ev=%b page=%h, got hit=%b ev=%b page=%h",
                        $realtime, want.hit, want.evicted_valid, want.evicted_page,
                        hit, evicted_valid, evicted_page);
         end
      endfunction
   endclass

endpackage

FILE: verif/tb.sv
// Testbench top for the LFU page store: directed corner cases, then random access phases.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lfu_pkg::*;
   import lfu_store_mirror_pkg::*;

   localparam int unsigned TABLE_DEPTH = 512;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [PAGE_W-1:0]   req_page_number = '0;
   logic [STAMP_W-1:0]  req_access_stamp = '0;
   logic                rsp_valid;
   logic                rsp_hit;
   logic                rsp_evicted_valid;
   logic [PAGE_W-1:0]   rsp_evicted_page;
   logic                csr_wr_en = 1'b0;
   logic [CFG_W-1:0]    csr_wr_data = '0;

   lfu_store_mirror     mirror;
   logic [STAMP_W-1:0]  stamp_clock;   // running stamp for well-ordered accesses

   lfu_page_replacement #(
      .MAX_FRAMES(TABLE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_page_number(req_page_number),
      .req_access_stamp(req_access_stamp),
      .rsp_valid(rsp_valid),
      .rsp_hit(rsp_hit),
      .rsp_evicted_valid(rsp_evicted_valid),
      .rsp_evicted_page(rsp_evicted_page),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   // Responses cannot be held off, so every strobe is checked on the edge that ends it.
   // Outputs are read in the active region, i.e. the values from before this edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         mirror.check_outcome(rsp_hit, rsp_evicted_valid, rsp_evicted_page);
   end

   // Present one request and hold it until the block takes it (start high, busy low).
   // start is left high so a back-to-back request never drops it within one step.
   task automatic send_access(input logic [PAGE_W-1:0] page, input logic [STAMP_W-1:0] stamp);
      start <= 1'b1;
      req_page_number <= page;
      req_access_stamp <= stamp;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      mirror.note_access(page, stamp);
   endtask

   // Stop sending and wait until every predicted response has come back.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (busy || mirror.due_outcomes.size() != 0)
         @(posedge clock);
   endtask

   // frames_in_use may only change while the block is idle.
   task automatic write_frames(input logic [CFG_W-1:0] value);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      mirror.frames_reg = value;
   endtask

   // One random phase at a given frame limit. Most pages come from a small pool so that
   // hits, count growth and LFU/LRU victim selection get exercised; the rest are fresh.
   task automatic run_phase(input logic [CFG_W-1:0] frames_value, input int unsigned count,
                            input int unsigned pool_size, input int unsigned fresh_pct);
      logic [PAGE_W-1:0]  pool[];
      logic [PAGE_W-1:0]  page;
      logic [STAMP_W-1:0] stamp;
      int unsigned        roll;
      int unsigned        gap;
      write_frames(frames_value);
      pool = new[pool_size];
      foreach (pool[i])
         pool[i] = $urandom;
      // a fresh origin lets new stamps land below resident ones, as after a wrap
      stamp_clock = $urandom;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(99, 0) < fresh_pct)
            page = $urandom;
         else
            page = pool[$urandom_range(pool_size - 1, 0)];
         // mostly increasing stamps, now and then an arbitrary one
         if ($urandom_range(9, 0) == 0) begin
            stamp = $urandom;
         end else begin
            stamp_clock += $urandom_range(3, 1);
            stamp = stamp_clock;
         end
         send_access(page, stamp);
         if ($urandom_range(99, 0) == 0) begin
            // sender holds off until the pipe is empty
            drain();
         end else if (k % 64 >= 24) begin
            // first part of every 64 requests runs back to back, then random gaps:
            // mostly short, a few long
            roll = $urandom_range(99, 0);
            if (roll < 55)
               gap = 0;
            else if (roll < 85)
               gap = $urandom_range(3, 1);
            else if (roll < 97)
               gap = $urandom_range(20, 4);
            else
               gap = $urandom_range(120, 30);
            if (gap != 0) begin
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   endtask

   initial begin
      int unsigned failures;
      mirror = new(TABLE_DEPTH);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // zero frames behaves as a single frame: fill, hit, then replace on every miss
      write_frames(10'd0);
      send_access(32'h0000_0000, 32'h0000_0000);
      send_access(32'h0000_0000, 32'h0000_0001);
      send_access(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_access(32'hA5A5_A5A5, 32'h0000_0002);

      // three frames: count ties broken by stamp, stamp ties by lowest slot
      write_frames(10'd3);
      send_access(32'h5A5A_5A5A, 32'h0000_000A);
      send_access(32'h0000_0001, 32'h0000_000A);   // same stamp as the entry above
      send_access(32'hA5A5_A5A5, 32'h0000_0014);   // hit, count goes to two
      send_access(32'h8000_0000, 32'h0000_001E);   // full tie on the two single-use entries
      send_access(32'h0000_0002, 32'hFFFF_FFF0);
      send_access(32'h0000_0003, 32'h0000_0005);   // wrapped stamp, counts as oldest
      send_access(32'h0000_0004, 32'h0000_0006);
      send_access(32'h0000_0002, 32'h0000_0007);   // hit
      send_access(32'hA5A5_A5A5, 32'h0000_0008);   // hit
      send_access(32'h0000_0005, 32'h0000_0009);

      // limit lowered below the fill: nothing dropped, every miss replaces
      write_frames(10'd1);
      send_access(32'h0000_0006, 32'h0000_000B);
      send_access(32'h0000_0006, 32'h0000_000C);
      send_access(32'h0000_0007, 32'h0000_000D);

      // --- random part ---
      // small limits first: the fill never shrinks, and scan time follows the fill
      run_phase(10'd2, 100, 6, 15);
      run_phase(10'd5, 100, 12, 15);
      run_phase(10'd1, 80, 6, 20);
      run_phase(10'd8, 110, 18, 15);
      run_phase(10'd16, 120, 34, 15);
      run_phase(10'd11, 90, 26, 15);
      // large limits: mostly fresh pages so the store fills up to the table size,
      // and the oversize setting has to clamp once it is full
      run_phase(10'd512, 240, 32, 97);
      run_phase(10'd1023, 300, 32, 97);
      run_phase(10'd4, 30, 8, 20);

      drain();
      repeat (TABLE_DEPTH + 8) @(posedge clock);
      failures = mirror.mismatches + mirror.due_outcomes.size();
      if (failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Watchdog: well beyond the slowest legal run with a full table.
   initial begin
      #30ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+design
design/lfu_pkg.sv
design/lfu_ram.sv
design/lfu_cmp.sv
design/lfu_page_replacement.sv
design/lfu_checker.sv
verif/lfu_store_mirror_pkg.sv
verif/tb.sv
